>>> src/tendon_organ_iir_rate_defines.svh
// Assertion macros for the checker of the tendon organ rate block.
// Depends on nothing; the checker file includes it by name.
`ifndef TENDON_ORGAN_IIR_RATE_DEFINES_SVH
`define TENDON_ORGAN_IIR_RATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed at the current edge");

// Next-cycle implication, disabled while reset is asserted.
`define TOIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed one edge later");

`endif

>>> src/toir_pkg.sv
// Shared types, constants and helpers of the tendon organ rate block.
// Depends on nothing; used by the datapath, the top level and the checker.
`timescale 1ns / 1ps

package toir_pkg;

  localparam int SampleWidth  = 32;
  localparam int CoefWidth    = 32;
  localparam int CoefFracBits = 28;
  localparam int ProdWidth    = SampleWidth + CoefWidth;
  // Five products summed need three guard bits.
  localparam int AccWidth     = ProdWidth + 3;
  localparam int RoundWidth   = AccWidth - CoefFracBits;
  localparam int CfgIdxWidth  = 3;
  // A configuration word carries either a sample level or a coefficient.
  localparam int CfgDataWidth = (SampleWidth > CoefWidth) ? SampleWidth : CoefWidth;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic signed [RoundWidth-1:0]  round_t;

  localparam acc_t RoundHalf = acc_t'(1) <<< (CoefFracBits - 1);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgThreshold  = 3'd0,
    CfgSaturation = 3'd1,
    CfgFfCoef0    = 3'd2,
    CfgFfCoef1    = 3'd3,
    CfgFfCoef2    = 3'd4,
    CfgFbCoef1    = 3'd5,
    CfgFbCoef2    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    sample_t threshold;
    sample_t saturation;
    coef_t   ff_coef0;
    coef_t   ff_coef1;
    coef_t   ff_coef2;
    coef_t   fb_coef1;
    coef_t   fb_coef2;
  } toir_cfg_t;

  typedef struct packed {
    sample_t excess1;
    sample_t excess2;
    sample_t rate1;
    sample_t rate2;
  } toir_hist_t;

  // Saturate a wider signed value to the sample range.
  function automatic sample_t sat_sample(input round_t v);
    logic [RoundWidth-SampleWidth:0] top;
    top = v[RoundWidth-1:SampleWidth-1];
    if ((&top) || !(|top)) begin
      return v[SampleWidth-1:0];
    end else if (v[RoundWidth-1]) begin
      return {1'b1, {(SampleWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(SampleWidth-1){1'b1}}};
    end
  endfunction

endpackage

>>> src/toir_biquad.sv
// Combinational dead zone, clamp and biquad for one force word.
// Depends on toir_pkg for the sample, coefficient and history types.
`timescale 1ns / 1ps

module toir_biquad (
  input  toir_pkg::sample_t    force_sample_i,
  input  toir_pkg::toir_cfg_t  cfg_i,
  input  toir_pkg::toir_hist_t hist_i,
  output toir_pkg::sample_t    excess_o,
  output toir_pkg::sample_t    rate_o
);
  import toir_pkg::*;

  logic signed [SampleWidth:0] live_diff;
  logic signed [SampleWidth:0] clamp_diff;
  sample_t excess_live;
  sample_t excess_clamp;
  logic signed [ProdWidth-1:0] prod_ff0, prod_ff1, prod_ff2, prod_fb1, prod_fb2;
  acc_t acc;
  acc_t acc_rnd;
  sample_t rate_filt;
  logic    in_clamp;
  logic    in_dead;

  assign live_diff  = {force_sample_i[SampleWidth-1], force_sample_i}
                    - {cfg_i.threshold[SampleWidth-1], cfg_i.threshold};
  assign clamp_diff = {cfg_i.saturation[SampleWidth-1], cfg_i.saturation}
                    - {cfg_i.threshold[SampleWidth-1], cfg_i.threshold};

  assign excess_live  = sat_sample(round_t'(live_diff));
  assign excess_clamp = sat_sample(round_t'(clamp_diff));

  // Five independent products, summed exactly.
  assign prod_ff0 = cfg_i.ff_coef0 * excess_live;
  assign prod_ff1 = cfg_i.ff_coef1 * hist_i.excess1;
  assign prod_ff2 = cfg_i.ff_coef2 * hist_i.excess2;
  assign prod_fb1 = cfg_i.fb_coef1 * hist_i.rate1;
  assign prod_fb2 = cfg_i.fb_coef2 * hist_i.rate2;

  assign acc = acc_t'(prod_ff0) + acc_t'(prod_ff1) + acc_t'(prod_ff2)
             - acc_t'(prod_fb1) - acc_t'(prod_fb2);

  // Round to nearest with ties upward, then drop the fraction bits.
  assign acc_rnd   = acc + RoundHalf;
  assign rate_filt = sat_sample($signed(acc_rnd[AccWidth-1:CoefFracBits]));

  // The clamp test wins over the dead zone.
  assign in_clamp = (force_sample_i >= cfg_i.saturation);
  assign in_dead  = (force_sample_i <= cfg_i.threshold);

  always_comb begin
    if (in_clamp) begin
      excess_o = excess_clamp;
      rate_o   = hist_i.rate1;
    end else if (in_dead) begin
      excess_o = '0;
      rate_o   = hist_i.rate1;
    end else begin
      excess_o = excess_live;
      rate_o   = rate_filt;
    end
  end

endmodule

>>> src/tendon_organ_iir_rate.sv
// Top level of the tendon force to afferent firing rate converter.
// Depends on toir_pkg and the toir_biquad datapath.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, force_sample_i    | in
//   output  | out_valid_o, out_ready_i, firing_rate_o   | out
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//           | cfg_data_i                                |
//
// One word per cycle is sustained while the output is not stalled; an accepted
// word waits in the input register and moves into the output register once that
// register is empty or being drained. The single pass through five parallel 32x32
// multipliers and the rounding adder lies between the input register and the
// history registers, and each word needs it whole, because each rate feeds the next.
// Reset restores the default registers and clears the filter history.
// A stalled output holds one word while the input register holds the next.
`timescale 1ns / 1ps

module tendon_organ_iir_rate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  toir_pkg::sample_t                   force_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output toir_pkg::sample_t                   firing_rate_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [toir_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [toir_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import toir_pkg::*;

  // Configuration registers.
  toir_cfg_t cfg_q;

  // Input register: one accepted word waiting for the datapath.
  logic    in_valid_q;
  sample_t force_q;

  // Output register.
  logic    out_valid_q;
  sample_t rate_q;

  // Filter history.
  toir_hist_t hist_q;

  sample_t excess_next;
  sample_t rate_next;
  logic    advance;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= '0;
      cfg_q.saturation <= {1'b0, {(SampleWidth-1){1'b1}}};
      cfg_q.ff_coef0   <= '0;
      cfg_q.ff_coef1   <= '0;
      cfg_q.ff_coef2   <= '0;
      cfg_q.fb_coef1   <= '0;
      cfg_q.fb_coef2   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold:  cfg_q.threshold  <= cfg_data_i[SampleWidth-1:0];
        CfgSaturation: cfg_q.saturation <= cfg_data_i[SampleWidth-1:0];
        CfgFfCoef0:    cfg_q.ff_coef0   <= cfg_data_i[CoefWidth-1:0];
        CfgFfCoef1:    cfg_q.ff_coef1   <= cfg_data_i[CoefWidth-1:0];
        CfgFfCoef2:    cfg_q.ff_coef2   <= cfg_data_i[CoefWidth-1:0];
        CfgFbCoef1:    cfg_q.fb_coef1   <= cfg_data_i[CoefWidth-1:0];
        CfgFbCoef2:    cfg_q.fb_coef2   <= cfg_data_i[CoefWidth-1:0];
        default: ;
      endcase
    end
  end

  // The word in the input register moves on whenever the output register
  // is empty or is being drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      force_q <= force_sample_i;
    end
  end

  toir_biquad u_biquad (
    .force_sample_i (force_q),
    .cfg_i          (cfg_q),
    .hist_i         (hist_q),
    .excess_o       (excess_next),
    .rate_o         (rate_next)
  );

  // History advances exactly once per word, when the word reaches the
  // output register, so the next word sees this word's rate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (advance) begin
      hist_q.excess2 <= hist_q.excess1;
      hist_q.excess1 <= excess_next;
      hist_q.rate2   <= hist_q.rate1;
      hist_q.rate1   <= rate_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rate_q <= rate_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign firing_rate_o = rate_q;

endmodule

>>> src/toir_checker.sv
// Port-level checker for the tendon organ rate block, bound to the top level.
// Depends on toir_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "tendon_organ_iir_rate_defines.svh"

module toir_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input toir_pkg::sample_t firing_rate_o
);
  import toir_pkg::*;

  // A stalled result stays offered.
  `TOIR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A stalled result keeps its value.
  `TOIR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(firing_rate_o))

  // The input only stalls when a result is waiting and not being taken.
  `TOIR_ASSERT_NOW(a_in_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // An accepted word, with a free output path, is offered once it has passed the input and output registers.
  `TOIR_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o)

endmodule

bind tendon_organ_iir_rate toir_checker u_toir_checker (.*);
